[hw/rtl/piea_pkg.sv]
// Package for the positional insert/erase array: operation and status codes,
// controller state type and the result record. No dependencies.

package piea_pkg;

    // Fixed field widths of the request and result ports
    localparam int OP_W  = 3;
    localparam int POS_W = 9;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND      = 3'd0,
        OP_REMOVE_LAST = 3'd1,
        OP_INSERT      = 3'd2,
        OP_ERASE       = 3'd3,
        OP_READ        = 3'd4,
        OP_WRITE       = 3'd5,
        OP_CLEAR       = 3'd6
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ_WAIT,
        S_SHIFT,
        S_FINAL
    } t_state;

    // One result transfer
    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] read_value;
        logic [POS_W-1:0] entry_count;
        t_status          status;
    } t_result;

endpackage

[hw/rtl/piea_ram.sv]
// Entry store: one write port and one read port, read data registered.
// No package dependencies.

module piea_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[hw/rtl/piea_ctrl.sv]
// Request sequencer: holds the entry count, decodes requests and drives the
// entry store, including the one-entry-per-cycle shift for insert and erase.
// Depends on piea_pkg.

module piea_ctrl #(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32,
    localparam int AW        = $clog2(CAPACITY)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [piea_pkg::OP_W-1:0]   i_operation,
    input  logic [piea_pkg::POS_W-1:0]  i_position,
    input  logic [piea_pkg::VAL_W-1:0]  i_item_value,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [DATA_WIDTH-1:0]       o_mem_wdata,
    output logic                        o_mem_re,
    output logic [AW-1:0]               o_mem_raddr,
    input  logic [DATA_WIDTH-1:0]       i_mem_rdata,
    output piea_pkg::t_result           o_result
);

    import piea_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_left, n_left;
    logic [AW-1:0]         r_rd_ptr, n_rd_ptr;
    logic                  r_wr_pend, n_wr_pend;
    logic [AW-1:0]         r_wr_addr, n_wr_addr;

    logic [XW-1:0] pos_ext;
    logic [XW-1:0] cnt_ext;
    logic          ins_range;
    logic          acc_range;
    logic          is_full;
    logic          is_empty;
    logic          is_insert;

    // Bound checks against the current count
    assign pos_ext   = XW'(r_pos);
    assign cnt_ext   = XW'(r_count);
    assign ins_range = pos_ext > cnt_ext;
    assign acc_range = pos_ext >= cnt_ext;
    assign is_full   = r_count >= CW'(CAPACITY);
    assign is_empty  = r_count == '0;
    assign is_insert = r_op == OP_INSERT;

    assign busy = r_state != S_IDLE;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_op)
                    OP_READ: begin
                        if (!acc_range) begin
                            n_state = S_READ_WAIT;
                        end
                    end
                    OP_INSERT: begin
                        if (!ins_range && !is_full) begin
                            n_state = S_SHIFT;
                        end
                    end
                    OP_ERASE: begin
                        if (!acc_range) begin
                            n_state = S_SHIFT;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_READ_WAIT: n_state = S_IDLE;
            S_SHIFT: begin
                if (r_left == '0) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory controls and result
    always_comb begin
        n_op      = r_op;
        n_pos     = r_pos;
        n_val     = r_val;
        n_count   = r_count;
        n_left    = r_left;
        n_rd_ptr  = r_rd_ptr;
        n_wr_pend = 1'b0;
        n_wr_addr = r_wr_addr;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_rd_ptr;
        // a shift move writes back the word read in the previous cycle
        o_mem_we    = r_wr_pend;
        o_mem_waddr = r_wr_addr;
        o_mem_wdata = i_mem_rdata;
        o_result        = '0;
        o_result.status = ST_DONE;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = t_op'(i_operation);
                    n_pos = i_position;
                    n_val = DATA_WIDTH'(64'($signed(i_item_value)));
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_APPEND: begin
                        o_result.valid = 1'b1;
                        if (is_full) begin
                            o_result.status = ST_FULL;
                        end else begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = AW'(r_count);
                            o_mem_wdata = r_val;
                            n_count     = r_count + 1'b1;
                        end
                    end
                    OP_REMOVE_LAST: begin
                        o_result.valid = 1'b1;
                        if (is_empty) begin
                            o_result.status = ST_EMPTY;
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                    end
                    OP_INSERT: begin
                        if (ins_range) begin
                            o_result.valid  = 1'b1;
                            o_result.status = ST_RANGE;
                        end else if (is_full) begin
                            o_result.valid  = 1'b1;
                            o_result.status = ST_FULL;
                        end else begin
                            // move count-1 down to pos, each up by one
                            n_left   = CW'(cnt_ext - pos_ext);
                            n_rd_ptr = AW'(r_count - 1'b1);
                        end
                    end
                    OP_ERASE: begin
                        if (acc_range) begin
                            o_result.valid  = 1'b1;
                            o_result.status = ST_RANGE;
                        end else begin
                            // move pos+1 up to count-1, each down by one
                            n_left   = CW'(cnt_ext - pos_ext - 1'b1);
                            n_rd_ptr = AW'(pos_ext + 1'b1);
                        end
                    end
                    OP_READ: begin
                        if (acc_range) begin
                            o_result.valid  = 1'b1;
                            o_result.status = ST_RANGE;
                        end else begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = AW'(r_pos);
                        end
                    end
                    OP_WRITE: begin
                        o_result.valid = 1'b1;
                        if (acc_range) begin
                            o_result.status = ST_RANGE;
                        end else begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = AW'(r_pos);
                            o_mem_wdata = r_val;
                        end
                    end
                    OP_CLEAR: begin
                        o_result.valid = 1'b1;
                        n_count        = '0;
                    end
                    default: o_result.valid = 1'b1;
                endcase
            end
            S_READ_WAIT: begin
                o_result.valid      = 1'b1;
                o_result.read_value = VAL_W'(64'($signed(i_mem_rdata)));
            end
            S_SHIFT: begin
                if (r_left != '0) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_rd_ptr;
                    n_wr_pend   = 1'b1;
                    n_left      = r_left - 1'b1;
                    if (is_insert) begin
                        n_wr_addr = r_rd_ptr + 1'b1;
                        n_rd_ptr  = r_rd_ptr - 1'b1;
                    end else begin
                        n_wr_addr = r_rd_ptr - 1'b1;
                        n_rd_ptr  = r_rd_ptr + 1'b1;
                    end
                end
            end
            S_FINAL: begin
                o_result.valid = 1'b1;
                if (is_insert) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = AW'(r_pos);
                    o_mem_wdata = r_val;
                    n_count     = r_count + 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            default: o_result.valid = 1'b0;
        endcase

        o_result.entry_count = POS_W'(n_count);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_wr_pend <= n_wr_pend;
        end
    end

    // Request and pointer registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_left    <= n_left;
        r_rd_ptr  <= n_rd_ptr;
        r_wr_addr <= n_wr_addr;
    end

`ifndef SYNTHESIS
    // Count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // A move write-back is finished before the final insert write
    a_final_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL) |-> !r_wr_pend)
        else $error("move write overlaps final write");

    // Each shift read is followed by its write-back
    a_move_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_left != '0) |=> (r_wr_pend && o_mem_we))
        else $error("shift read without write-back");

    // An accepted request always reaches decode
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_EXEC))
        else $error("accepted request not decoded");

    // Only the terminal states issue a result
    a_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (r_state == S_EXEC || r_state == S_READ_WAIT ||
                            r_state == S_FINAL))
        else $error("result outside terminal state");
`endif

endmodule

[hw/rtl/positional_insert_erase_array_core.sv]
// Top level of the positional insert/erase array: sequencer, entry store and
// result register. Depends on piea_pkg, piea_ctrl and piea_ram.

// Usage: a request transfers at a clock edge where start is high and busy is
// low; busy stays high while it runs. Its one result appears for a single
// cycle with o_valid high and cannot be held off, so the receiver must take
// it then. Insert and erase hold busy high while the shift moves the entries
// (count minus position for insert, count minus position minus one for
// erase) one entry per cycle through the store's read and write ports;
// refused requests do not shift. The result is on the ports in the first
// cycle in which busy is low again. The store needs no clearing after reset.

module positional_insert_erase_array_core #(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [piea_pkg::OP_W-1:0]         i_operation,
    input  logic [piea_pkg::POS_W-1:0]        i_position,
    input  logic signed [piea_pkg::VAL_W-1:0] i_item_value,
    output logic                              o_valid,
    output logic signed [piea_pkg::VAL_W-1:0] o_read_value,
    output logic [piea_pkg::POS_W-1:0]        o_entry_count,
    output logic [piea_pkg::ST_W-1:0]         o_status
);

    import piea_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;
    t_result               result;
    t_result               r_out;

    // Sequencer
    piea_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata),
        .o_result     (result)
    );

    // Entry store
    piea_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Result register: one-cycle transfer strobe, payload without reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= result.valid;
        end
        r_out.read_value  <= result.read_value;
        r_out.entry_count <= result.entry_count;
        r_out.status      <= result.status;
    end

    assign o_valid       = r_out.valid;
    assign o_read_value  = r_out.read_value;
    assign o_entry_count = r_out.entry_count;
    assign o_status      = r_out.status;

endmodule

[tb/piea_result_checker.sv]
// Result checker for the positional insert/erase array: shadows the entry store and
// count, predicts one reply per accepted request and compares every reply field.
// Depends on piea_pkg.

module piea_result_checker #(
    parameter int CAPACITY = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [piea_pkg::OP_W-1:0]         i_operation,
    input  logic [piea_pkg::POS_W-1:0]        i_position,
    input  logic [piea_pkg::VAL_W-1:0]        i_item_value,
    input  logic                              i_valid,
    input  logic [piea_pkg::VAL_W-1:0]        i_read_value,
    input  logic [piea_pkg::POS_W-1:0]        i_entry_count,
    input  logic [piea_pkg::ST_W-1:0]         i_status,
    output int                                o_fail_count,
    output int                                o_pending,
    output logic [piea_pkg::POS_W-1:0]        o_held_count
);
    import piea_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    typedef struct {
        logic [VAL_W-1:0] read_value;
        logic [POS_W-1:0] entry_count;
        logic [ST_W-1:0]  status;
    } t_reply;

    // Shadow of the array contents and its fill level
    logic [VAL_W-1:0] shadow_entries [CAPACITY];
    logic [POS_W-1:0] shadow_count;
    t_reply           pending_replies [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_held_count = '0;
        shadow_count = '0;
    end

    // Apply one request to the shadow array and queue the reply it should produce
    task automatic predict_array_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                    input logic [VAL_W-1:0] val);
        t_reply r;
        int     i;
        r.read_value = '0;
        r.status     = ST_DONE;
        case (op)
            OP_APPEND: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_entries[AW'(shadow_count)] = val;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            OP_REMOVE_LAST: begin
                if (shadow_count == 0) r.status = ST_EMPTY;
                else shadow_count = shadow_count - 1'b1;
            end
            OP_INSERT: begin
                // position is checked before capacity
                if (pos > shadow_count) begin
                    r.status = ST_RANGE;
                end else if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = int'(shadow_count); i > int'(pos); i--)
                        shadow_entries[AW'(i)] = shadow_entries[AW'(i-1)];
                    shadow_entries[AW'(pos)] = val;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            OP_ERASE: begin
                if (pos >= shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = int'(pos); i + 1 < int'(shadow_count); i++)
                        shadow_entries[AW'(i)] = shadow_entries[AW'(i+1)];
                    shadow_count = shadow_count - 1'b1;
                end
            end
            OP_READ: begin
                if (pos >= shadow_count) r.status = ST_RANGE;
                else r.read_value = shadow_entries[AW'(pos)];
            end
            OP_WRITE: begin
                if (pos >= shadow_count) r.status = ST_RANGE;
                else shadow_entries[AW'(pos)] = val;
            end
            OP_CLEAR: shadow_count = '0;
            default: ;  // unused code: no effect
        endcase
        r.entry_count = shadow_count;
        pending_replies.insert(pending_replies.size(), r);
    endtask

    task automatic report_field(input string name, input logic [VAL_W-1:0] want,
                                input logic [VAL_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    // Compare replies first, then record a request accepted at the same edge
    always @(posedge i_clk) begin : watch_channels
        t_reply want;
        if (!i_rst_n) begin
            shadow_count = '0;
            pending_replies.delete();
        end else begin
            if (i_valid === 1'b1) begin
                if (pending_replies.size() == 0) begin
                    $display({"%0t: unexpected reply: expected none, ",
                              "actual value %h count %0d status %0d"},
                             $time, i_read_value, i_entry_count, i_status);
                    o_fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    report_field("read_value", want.read_value, i_read_value);
                    report_field("entry_count", VAL_W'(want.entry_count), VAL_W'(i_entry_count));
                    report_field("status", VAL_W'(want.status), VAL_W'(i_status));
                end
            end
            if (i_start && !i_busy)
                predict_array_op(i_operation, i_position, i_item_value);
        end
        o_pending    = pending_replies.size();
        o_held_count = shadow_count;
    end

endmodule

[tb/testbench.sv]
// Top of the positional insert/erase array testbench: clock, reset, request stimulus,
// watchdog and verdict. Depends on piea_pkg, positional_insert_erase_array_core and
// piea_result_checker.

module testbench;
    import piea_pkg::*;

    localparam int               CAPACITY       = 256;
    localparam int               ITEM_TOTAL     = 1200;
    localparam int               CALM_TAIL      = 150;
    localparam int               WATCHDOG_LIMIT = 8 * (CAPACITY + 20);
    localparam logic [OP_W-1:0]  OP_UNUSED      = 3'd7;
    localparam logic [VAL_W-1:0] VAL_MAX        = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] VAL_MIN        = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAL_ONES       = 32'hffff_ffff;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_operation;
    logic [POS_W-1:0]  i_position;
    logic [VAL_W-1:0]  i_item_value;
    logic              o_valid;
    logic [VAL_W-1:0]  o_read_value;
    logic [POS_W-1:0]  o_entry_count;
    logic [ST_W-1:0]   o_status;

    int                fail_count;
    int                replies_owed;
    logic [POS_W-1:0]  model_held;
    int                item_idx = 0;
    int                idle_mode = 0;
    int                stall_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    positional_insert_erase_array_core #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (VAL_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    piea_result_checker #(
        .CAPACITY (CAPACITY)
    ) reply_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .i_valid       (o_valid),
        .i_read_value  (o_read_value),
        .i_entry_count (o_entry_count),
        .i_status      (o_status),
        .o_fail_count  (fail_count),
        .o_pending     (replies_owed),
        .o_held_count  (model_held)
    );

    // Watchdog: too long without any transfer on either side ends the run
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid === 1'b1) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Called at a falling edge: drive one request and hold it until it transfers
    task automatic issue(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic [VAL_W-1:0] val);
        start        <= 1'b1;
        i_operation  <= op;
        i_position   <= pos;
        i_item_value <= val;
        do @(posedge i_clk); while (busy);
    endtask

    // Next falling edge, with an occasional burst of idle cycles before the request
    task automatic next_slot();
        int chance;
        @(negedge i_clk);
        if (item_idx < ITEM_TOTAL - CALM_TAIL) begin
            if (item_idx % 32 == 0) idle_mode = $urandom_range(0, 2);
            chance = (idle_mode == 0) ? 0 : (idle_mode == 1) ? 15 : 50;
            if ($urandom_range(0, 99) < chance) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end
        end
        item_idx++;
    endtask

    // Hold off the sender until every owed reply has come back
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (replies_owed != 0) @(negedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return VAL_ONES;
            default: return $urandom;
        endcase
    endfunction

    // One random request, mostly well-formed for the current fill level
    task automatic random_request();
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        int               h;
        int               r;
        next_slot();
        h = int'(model_held);
        r = $urandom_range(0, 99);
        if (r < 20)      op = OP_APPEND;
        else if (r < 30) op = OP_REMOVE_LAST;
        else if (r < 48) op = OP_INSERT;
        else if (r < 64) op = OP_ERASE;
        else if (r < 79) op = OP_READ;
        else if (r < 94) op = OP_WRITE;
        else if (r < 97) op = OP_CLEAR;
        else             op = OP_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        end else if (r < 22) begin
            // boundaries of the held range
            case ($urandom_range(0, 2))
                0:       pos = '0;
                1:       pos = POS_W'(h);
                default: pos = POS_W'((h > 0) ? h - 1 : 0);
            endcase
        end else if (op == OP_INSERT) begin
            pos = POS_W'($urandom_range(0, h));
        end else begin
            pos = (h > 0) ? POS_W'($urandom_range(0, h - 1)) : '0;
        end
        issue(op, pos, pick_value());
    endtask

    // Fill the store to capacity, then probe the full-store cases
    task automatic fill_and_probe();
        next_slot(); issue(OP_CLEAR, '0, '0);
        while (int'(model_held) < CAPACITY) begin
            next_slot();
            issue(OP_APPEND, POS_W'($urandom_range(0, (1 << POS_W) - 1)), pick_value());
        end
        next_slot(); issue(OP_APPEND, '0, VAL_MAX);
        next_slot(); issue(OP_INSERT, '0, VAL_MIN);
        next_slot(); issue(OP_INSERT, POS_W'(CAPACITY), VAL_ONES);
        next_slot(); issue(OP_INSERT, POS_W'(CAPACITY + 1), VAL_ONES);
        next_slot(); issue(OP_READ, POS_W'(CAPACITY - 1), '0);
        next_slot(); issue(OP_WRITE, POS_W'(CAPACITY - 1), VAL_MIN);
        next_slot(); issue(OP_READ, POS_W'(CAPACITY - 1), '0);
        next_slot(); issue(OP_READ, POS_W'(CAPACITY), '0);
        next_slot(); issue(OP_ERASE, '0, '0);
        next_slot(); issue(OP_READ, '0, '0);
        next_slot(); issue(OP_INSERT, '0, VAL_MAX);
        next_slot(); issue(OP_READ, '0, '0);
        next_slot(); issue(OP_REMOVE_LAST, '0, '0);
        next_slot(); issue(OP_ERASE, POS_W'(CAPACITY - 2), '0);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_operation  = '0;
        i_position   = '0;
        i_item_value = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: refusals on an empty store, extremes, shifts at the edges
        next_slot(); issue(OP_REMOVE_LAST, '0, '0);
        next_slot(); issue(OP_ERASE, '0, '0);
        next_slot(); issue(OP_READ, '0, '0);
        next_slot(); issue(OP_WRITE, '0, VAL_MAX);
        next_slot(); issue(OP_INSERT, 9'd1, VAL_MAX);
        next_slot(); issue(OP_CLEAR, '0, '0);
        next_slot(); issue(OP_UNUSED, 9'h1ff, VAL_ONES);
        next_slot(); issue(OP_APPEND, '0, VAL_MAX);
        next_slot(); issue(OP_APPEND, 9'h1ff, VAL_MIN);
        next_slot(); issue(OP_INSERT, '0, VAL_ONES);
        next_slot(); issue(OP_INSERT, 9'd3, '0);
        next_slot(); issue(OP_INSERT, 9'd5, VAL_MAX);
        next_slot(); issue(OP_READ, 9'd0, '0);
        next_slot(); issue(OP_READ, 9'd1, '0);
        next_slot(); issue(OP_READ, 9'd2, '0);
        next_slot(); issue(OP_READ, 9'd3, '0);
        next_slot(); issue(OP_WRITE, 9'd2, 32'h1234_5678);
        next_slot(); issue(OP_READ, 9'd2, '0);
        next_slot(); issue(OP_ERASE, 9'd1, '0);
        next_slot(); issue(OP_ERASE, 9'd2, '0);
        next_slot(); issue(OP_READ, 9'h1ff, '0);
        next_slot(); issue(OP_WRITE, 9'h100, VAL_MIN);
        next_slot(); issue(OP_REMOVE_LAST, '0, '0);
        next_slot(); issue(OP_CLEAR, '0, '0);
        wait_drained();

        // Random part, with two full-capacity episodes
        while (item_idx < ITEM_TOTAL) begin
            if (item_idx == 200 || item_idx == 700) begin
                fill_and_probe();
                wait_drained();
            end else begin
                random_request();
            end
        end

        wait_drained();
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (fail_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
hw/rtl/piea_pkg.sv
hw/rtl/piea_ram.sv
hw/rtl/piea_ctrl.sv
hw/rtl/positional_insert_erase_array_core.sv
tb/piea_result_checker.sv
tb/testbench.sv
